FILE: rtl/core/assert_macros.svh
// Assertion helpers for the ranking table checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RTK_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RTK_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/core/rtk_pkg.sv
`default_nettype none
package rtk_pkg;

   localparam int RANK_DEPTH_DEF  = 64;
   localparam int TABLE_COUNT_DEF = 8;

   // action codes
   localparam logic [2:0] ACT_UPDATE     = 3'd0;
   localparam logic [2:0] ACT_LOOKUP     = 3'd1;
   localparam logic [2:0] ACT_READ_RANK  = 3'd2;
   localparam logic [2:0] ACT_SET_GROUP  = 3'd3;
   localparam logic [2:0] ACT_REMOVE     = 3'd4;
   localparam logic [2:0] ACT_REMOVE_ALL = 3'd5;
   localparam logic [2:0] ACT_CLEAR_RANK = 3'd6;
   localparam logic [2:0] ACT_CLEAR_TBL  = 3'd7;

   // result status codes
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_IGNORED = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;

   typedef struct packed {
      logic [2:0]         action;
      logic [2:0]         table_sel;
      logic [31:0]        player_key;
      logic signed [31:0] score;
      logic [15:0]        group_id;
      logic [15:0]        title_id;
      logic [7:0]         job_class;
      logic [15:0]        player_level;
      logic [7:0]         rebirth_level;
      logic               sex_flag;
      logic [5:0]         rank_index;
   } rtk_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [31:0]        out_key;
      logic signed [31:0] out_score;
      logic [15:0]        out_group;
      logic [15:0]        out_title;
      logic [7:0]         out_job;
      logic [15:0]        out_level;
      logic [7:0]         out_rebirth;
      logic               out_sex;
      logic [5:0]         out_rank;
   } rtk_rsp_type;

   // one table slot as stored in memory
   typedef struct packed {
      logic [31:0]        key;
      logic signed [31:0] score;
      logic [15:0]        group;
      logic [15:0]        title;
      logic [7:0]         job;
      logic [15:0]        level;
      logic [7:0]         rebirth;
      logic               sex;
   } rtk_entry_type;

   typedef enum logic [2:0] {
      IDX_HOLD, IDX_ZERO, IDX_INC, IDX_DEC, IDX_RANK, IDX_LAST
   } rtk_idx_op_type;

   typedef enum logic [1:0] {TBL_HOLD, TBL_ZERO, TBL_INC} rtk_tbl_op_type;
   typedef enum logic [1:0] {RD_NONE, RD_IDX, RD_NEXT, RD_PREV} rtk_rd_op_type;
   typedef enum logic [1:0] {WR_NONE, WR_MOVE, WR_NEW, WR_GROUP} rtk_wr_op_type;
   typedef enum logic [1:0] {CNT_HOLD, CNT_CLEAR, CNT_DEC, CNT_INC} rtk_cnt_op_type;
   typedef enum logic [1:0] {SRC_ZERO, SRC_RDATA, SRC_GROUP, SRC_NEW} rtk_src_type;
   typedef enum logic [1:0] {RK_ZERO, RK_MARK, RK_ITEM} rtk_rank_sel_type;

   typedef struct packed {
      logic             load;
      rtk_idx_op_type   idx_op;
      rtk_tbl_op_type   tbl_op;
      rtk_rd_op_type    rd_op;
      rtk_wr_op_type    wr_op;
      rtk_cnt_op_type   cnt_op;
      logic             mark;
      logic             res_load;
      logic [1:0]       res_status;
      rtk_src_type      res_src;
      rtk_rank_sel_type res_rank;
   } rtk_cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       tbl_bad;
      logic       level_low;
      logic       rank_bad;
      logic       idx_at_count;
      logic       idx_at_rank;
      logic       next_at_count;
      logic       key_hit;
      logic       score_eq;
      logic       score_lt;
      logic       room;
      logic       last_tbl;
      logic       slot_free;
   } rtk_stat_type;

endpackage
`default_nettype wire

FILE: rtl/core/top_k_ranking_table.sv
// Ranking table block: TABLE_COUNT tables of RANK_DEPTH entries, each kept
// sorted by descending signed score with unique keys.
// Input channel req_*: one word per action (update, lookup, read rank, set
// group, remove, remove from all tables, clear rank, clear table).
// Result channel rsp_*: exactly one word per accepted input word.
// csr_wen/csr_wdata write the minimum level for updates; write only when idle.
// One word is worked on at a time through a slot memory with separate read
// and write addresses and a registered read; each entry visited is first
// read, then compared or moved. Clear table and early rejects go straight to
// the result; read rank reads one slot; lookup, set group and remove scan
// for the key, and remove then closes the gap; update runs a key scan, a
// remove if the key is found, a position scan and a shift; remove from all
// tables runs the key scans of every table, with a remove where found.
// The next word is accepted in the cycle after a result is loaded, even while
// that result is still stalled; a finished result waits in its own state
// until the output register frees up.
// Reset empties all tables at once through per-table fill counts and clears
// the minimum level; the slot memory itself is not cleared.
`default_nettype none
module top_k_ranking_table #(
   parameter int RANK_DEPTH  = rtk_pkg::RANK_DEPTH_DEF,
   parameter int TABLE_COUNT = rtk_pkg::TABLE_COUNT_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  rtk_pkg::rtk_req_type req_word,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output rtk_pkg::rtk_rsp_type rsp_word,
   input  wire                  csr_wen,
   input  wire [15:0]           csr_wdata
);
   rtk_pkg::rtk_cmd_type  cmd;
   rtk_pkg::rtk_stat_type stat;

   rtk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rtk_dpath #(
      .RANK_DEPTH  (RANK_DEPTH),
      .TABLE_COUNT (TABLE_COUNT)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule
`default_nettype wire

FILE: rtl/core/rtk_dpath.sv
`default_nettype none
module rtk_dpath #(
   parameter int RANK_DEPTH  = rtk_pkg::RANK_DEPTH_DEF,
   parameter int TABLE_COUNT = rtk_pkg::TABLE_COUNT_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  rtk_pkg::rtk_req_type req_word,
   input  wire                  rsp_stall,
   output logic                 rsp_valid,
   output rtk_pkg::rtk_rsp_type rsp_word,
   input  wire                  csr_wen,
   input  wire [15:0]           csr_wdata,
   input  rtk_pkg::rtk_cmd_type cmd,
   output rtk_pkg::rtk_stat_type stat
);
   localparam int SLOTS = TABLE_COUNT * RANK_DEPTH;
   localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int IW    = $clog2(RANK_DEPTH + 1);
   localparam int TW    = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;

   rtk_pkg::rtk_entry_type mem [SLOTS];
   rtk_pkg::rtk_entry_type rd_ff;
   rtk_pkg::rtk_req_type   item_ff;
   rtk_pkg::rtk_rsp_type   rsp_ff, rsp_in;
   rtk_pkg::rtk_entry_type wdata, new_entry, grp_entry, src_entry;
   logic [IW-1:0]  cnt_ff [TABLE_COUNT];
   logic [IW-1:0]  idx_ff, idx_in, rank_ff, cnt_cur;
   logic [TW-1:0]  tbl_ff, tbl_in;
   logic [15:0]    min_level_ff;
   logic           rsp_valid_ff;
   logic [AW-1:0]  base, raddr, waddr;

   assign cnt_cur = cnt_ff[tbl_ff];
   assign base    = AW'(tbl_ff) * AW'(RANK_DEPTH);
   assign waddr   = base + AW'(idx_ff);

   // pick the read address
   always_comb begin
      case (cmd.rd_op)
         rtk_pkg::RD_NEXT: raddr = base + AW'(idx_ff) + AW'(1);
         rtk_pkg::RD_PREV: raddr = base + AW'(idx_ff) - AW'(1);
         default:          raddr = base + AW'(idx_ff);
      endcase
   end

   // build the entries that may be written or reported
   always_comb begin
      new_entry.key     = item_ff.player_key;
      new_entry.score   = item_ff.score;
      new_entry.group   = item_ff.group_id;
      new_entry.title   = item_ff.title_id;
      new_entry.job     = item_ff.job_class;
      new_entry.level   = item_ff.player_level;
      new_entry.rebirth = item_ff.rebirth_level;
      new_entry.sex     = item_ff.sex_flag;
      grp_entry         = rd_ff;
      grp_entry.group   = item_ff.group_id;
      case (cmd.wr_op)
         rtk_pkg::WR_NEW:   wdata = new_entry;
         rtk_pkg::WR_GROUP: wdata = grp_entry;
         default:           wdata = rd_ff;
      endcase
   end

   // slot memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_op != rtk_pkg::WR_NONE) begin
         mem[waddr] <= wdata;
      end
      if (cmd.rd_op != rtk_pkg::RD_NONE) begin
         rd_ff <= mem[raddr];
      end
   end

   // next index and table
   always_comb begin
      unique case (cmd.idx_op)
         rtk_pkg::IDX_ZERO: idx_in = '0;
         rtk_pkg::IDX_INC:  idx_in = idx_ff + IW'(1);
         rtk_pkg::IDX_DEC:  idx_in = idx_ff - IW'(1);
         rtk_pkg::IDX_RANK: idx_in = IW'(item_ff.rank_index);
         rtk_pkg::IDX_LAST: idx_in = (cnt_cur == IW'(RANK_DEPTH)) ?
                                     IW'(RANK_DEPTH - 1) : cnt_cur;
         default:           idx_in = idx_ff;
      endcase
      unique case (cmd.tbl_op)
         rtk_pkg::TBL_ZERO: tbl_in = '0;
         rtk_pkg::TBL_INC:  tbl_in = tbl_ff + TW'(1);
         default:           tbl_in = tbl_ff;
      endcase
   end

   // hold the item and walk pointers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_word;
         tbl_ff  <= TW'(req_word.table_sel);
         idx_ff  <= '0;
      end else begin
         tbl_ff <= tbl_in;
         idx_ff <= idx_in;
      end
      if (cmd.mark) begin
         rank_ff <= idx_ff;
      end
   end

   // fill counts per table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < TABLE_COUNT; t++) begin
            cnt_ff[t] <= '0;
         end
      end else begin
         case (cmd.cnt_op)
            rtk_pkg::CNT_CLEAR: cnt_ff[tbl_ff] <= '0;
            rtk_pkg::CNT_DEC:   cnt_ff[tbl_ff] <= cnt_cur - IW'(1);
            rtk_pkg::CNT_INC: begin
               if (cnt_cur != IW'(RANK_DEPTH)) begin
                  cnt_ff[tbl_ff] <= cnt_cur + IW'(1);
               end
            end
            default: ;
         endcase
      end
   end

   // level limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         min_level_ff <= '0;
      end else if (csr_wen) begin
         min_level_ff <= csr_wdata;
      end
   end

   // compose the result word
   always_comb begin
      case (cmd.res_src)
         rtk_pkg::SRC_RDATA: src_entry = rd_ff;
         rtk_pkg::SRC_GROUP: src_entry = grp_entry;
         rtk_pkg::SRC_NEW:   src_entry = new_entry;
         default:            src_entry = '0;
      endcase
      rsp_in.status      = cmd.res_status;
      rsp_in.out_key     = src_entry.key;
      rsp_in.out_score   = src_entry.score;
      rsp_in.out_group   = src_entry.group;
      rsp_in.out_title   = src_entry.title;
      rsp_in.out_job     = src_entry.job;
      rsp_in.out_level   = src_entry.level;
      rsp_in.out_rebirth = src_entry.rebirth;
      rsp_in.out_sex     = src_entry.sex;
      case (cmd.res_rank)
         rtk_pkg::RK_MARK: rsp_in.out_rank = 6'(rank_ff);
         rtk_pkg::RK_ITEM: rsp_in.out_rank = item_ff.rank_index;
         default:          rsp_in.out_rank = '0;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.res_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // status back to the controller
   always_comb begin
      stat.action        = item_ff.action;
      stat.tbl_bad       = int'(item_ff.table_sel) >= TABLE_COUNT;
      stat.level_low     = item_ff.player_level < min_level_ff;
      stat.rank_bad      = (int'(item_ff.rank_index) >= RANK_DEPTH) ||
                           (int'(item_ff.rank_index) >= int'(cnt_cur));
      stat.idx_at_count  = idx_ff == cnt_cur;
      stat.idx_at_rank   = idx_ff == rank_ff;
      stat.next_at_count = (idx_ff + IW'(1)) == cnt_cur;
      stat.key_hit       = rd_ff.key == item_ff.player_key;
      stat.score_eq      = rd_ff.score == item_ff.score;
      stat.score_lt      = rd_ff.score < item_ff.score;
      stat.room          = cnt_cur != IW'(RANK_DEPTH);
      stat.last_tbl      = tbl_ff == TW'(TABLE_COUNT - 1);
      stat.slot_free     = !rsp_valid_ff || !rsp_stall;
   end

endmodule
`default_nettype wire

FILE: rtl/core/rtk_ctrl.sv
`default_nettype none
module rtk_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  rtk_pkg::rtk_stat_type stat,
   output rtk_pkg::rtk_cmd_type  cmd
);
   typedef enum logic [12:0] {
      S_IDLE     = 13'b0000000000001,
      S_DISPATCH = 13'b0000000000010,
      S_SCAN     = 13'b0000000000100,
      S_SCAN_CHK = 13'b0000000001000,
      S_RM       = 13'b0000000010000,
      S_RM_WR    = 13'b0000000100000,
      S_POS      = 13'b0000001000000,
      S_POS_CHK  = 13'b0000010000000,
      S_SH       = 13'b0000100000000,
      S_SH_WR    = 13'b0001000000000,
      S_NEXT_TBL = 13'b0010000000000,
      S_READ     = 13'b0100000000000,
      S_FINISH   = 13'b1000000000000
   } rtk_state_type;

   rtk_state_type              state_ff, state_in;
   logic [1:0]                 status_ff, status_in;
   rtk_pkg::rtk_src_type       src_ff, src_in;
   rtk_pkg::rtk_rank_sel_type  rsel_ff, rsel_in;
   logic                       found_ff, found_in;

   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      src_in         = src_ff;
      rsel_in        = rsel_ff;
      found_in       = found_ff;
      cmd            = '0;
      cmd.idx_op     = rtk_pkg::IDX_HOLD;
      cmd.tbl_op     = rtk_pkg::TBL_HOLD;
      cmd.rd_op      = rtk_pkg::RD_NONE;
      cmd.wr_op      = rtk_pkg::WR_NONE;
      cmd.cnt_op     = rtk_pkg::CNT_HOLD;
      cmd.res_status = status_ff;
      cmd.res_src    = src_ff;
      cmd.res_rank   = rsel_ff;
      unique case (state_ff)
         // take a word
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               found_in = 1'b0;
               state_in = S_DISPATCH;
            end
         end
         // sort out the early exits and start the walk
         S_DISPATCH: begin
            status_in = rtk_pkg::ST_DONE;
            src_in    = rtk_pkg::SRC_ZERO;
            rsel_in   = rtk_pkg::RK_ZERO;
            if (stat.action == rtk_pkg::ACT_REMOVE_ALL) begin
               cmd.tbl_op = rtk_pkg::TBL_ZERO;
               state_in   = S_SCAN;
            end else if (stat.tbl_bad) begin
               status_in = rtk_pkg::ST_MISSING;
               state_in  = S_FINISH;
            end else begin
               unique case (stat.action)
                  rtk_pkg::ACT_UPDATE: begin
                     if (stat.level_low) begin
                        status_in = rtk_pkg::ST_IGNORED;
                        state_in  = S_FINISH;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  rtk_pkg::ACT_READ_RANK, rtk_pkg::ACT_CLEAR_RANK: begin
                     rsel_in = rtk_pkg::RK_ITEM;
                     if (stat.rank_bad) begin
                        status_in = rtk_pkg::ST_MISSING;
                        state_in  = S_FINISH;
                     end else begin
                        cmd.idx_op = rtk_pkg::IDX_RANK;
                        if (stat.action == rtk_pkg::ACT_READ_RANK) begin
                           src_in   = rtk_pkg::SRC_RDATA;
                           state_in = S_READ;
                        end else begin
                           state_in = S_RM;
                        end
                     end
                  end
                  rtk_pkg::ACT_CLEAR_TBL: begin
                     cmd.cnt_op = rtk_pkg::CNT_CLEAR;
                     state_in   = S_FINISH;
                  end
                  default: state_in = S_SCAN;
               endcase
            end
         end
         // read the slot named by the rank
         S_READ: begin
            cmd.rd_op = rtk_pkg::RD_IDX;
            state_in  = S_FINISH;
         end
         // search for the key
         S_SCAN: begin
            if (stat.idx_at_count) begin
               if (stat.action == rtk_pkg::ACT_UPDATE) begin
                  cmd.idx_op = rtk_pkg::IDX_ZERO;
                  state_in   = S_POS;
               end else if (stat.action == rtk_pkg::ACT_REMOVE_ALL) begin
                  state_in = S_NEXT_TBL;
               end else begin
                  status_in = rtk_pkg::ST_MISSING;
                  state_in  = S_FINISH;
               end
            end else begin
               cmd.rd_op = rtk_pkg::RD_IDX;
               state_in  = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (stat.key_hit) begin
               cmd.mark = 1'b1;
               rsel_in  = rtk_pkg::RK_MARK;
               unique case (stat.action)
                  rtk_pkg::ACT_UPDATE: begin
                     if (stat.score_eq) begin
                        status_in = rtk_pkg::ST_IGNORED;
                        src_in    = rtk_pkg::SRC_RDATA;
                        state_in  = S_FINISH;
                     end else begin
                        state_in = S_RM;
                     end
                  end
                  rtk_pkg::ACT_LOOKUP: begin
                     src_in   = rtk_pkg::SRC_RDATA;
                     state_in = S_FINISH;
                  end
                  rtk_pkg::ACT_SET_GROUP: begin
                     cmd.wr_op = rtk_pkg::WR_GROUP;
                     src_in    = rtk_pkg::SRC_GROUP;
                     state_in  = S_FINISH;
                  end
                  rtk_pkg::ACT_REMOVE_ALL: begin
                     found_in = 1'b1;
                     state_in = S_RM;
                  end
                  default: state_in = S_RM;
               endcase
            end else begin
               cmd.idx_op = rtk_pkg::IDX_INC;
               state_in   = S_SCAN;
            end
         end
         // close the gap at the index
         S_RM: begin
            if (stat.next_at_count) begin
               cmd.cnt_op = rtk_pkg::CNT_DEC;
               if (stat.action == rtk_pkg::ACT_UPDATE) begin
                  cmd.idx_op = rtk_pkg::IDX_ZERO;
                  state_in   = S_POS;
               end else if (stat.action == rtk_pkg::ACT_REMOVE_ALL) begin
                  state_in = S_NEXT_TBL;
               end else begin
                  state_in = S_FINISH;
               end
            end else begin
               cmd.rd_op = rtk_pkg::RD_NEXT;
               state_in  = S_RM_WR;
            end
         end
         S_RM_WR: begin
            cmd.wr_op  = rtk_pkg::WR_MOVE;
            cmd.idx_op = rtk_pkg::IDX_INC;
            state_in   = S_RM;
         end
         // find the insert position
         S_POS: begin
            if (stat.idx_at_count) begin
               if (stat.room) begin
                  cmd.mark   = 1'b1;
                  cmd.idx_op = rtk_pkg::IDX_LAST;
                  state_in   = S_SH;
               end else begin
                  status_in = rtk_pkg::ST_IGNORED;
                  src_in    = rtk_pkg::SRC_ZERO;
                  rsel_in   = rtk_pkg::RK_ZERO;
                  state_in  = S_FINISH;
               end
            end else begin
               cmd.rd_op = rtk_pkg::RD_IDX;
               state_in  = S_POS_CHK;
            end
         end
         S_POS_CHK: begin
            if (stat.score_lt) begin
               cmd.mark   = 1'b1;
               cmd.idx_op = rtk_pkg::IDX_LAST;
               state_in   = S_SH;
            end else begin
               cmd.idx_op = rtk_pkg::IDX_INC;
               state_in   = S_POS;
            end
         end
         // shift entries down, then drop the new one in
         S_SH: begin
            if (stat.idx_at_rank) begin
               cmd.wr_op  = rtk_pkg::WR_NEW;
               cmd.cnt_op = rtk_pkg::CNT_INC;
               status_in  = rtk_pkg::ST_DONE;
               src_in     = rtk_pkg::SRC_NEW;
               rsel_in    = rtk_pkg::RK_MARK;
               state_in   = S_FINISH;
            end else begin
               cmd.rd_op = rtk_pkg::RD_PREV;
               state_in  = S_SH_WR;
            end
         end
         S_SH_WR: begin
            cmd.wr_op  = rtk_pkg::WR_MOVE;
            cmd.idx_op = rtk_pkg::IDX_DEC;
            state_in   = S_SH;
         end
         // advance to the next table for a global remove
         S_NEXT_TBL: begin
            if (stat.last_tbl) begin
               status_in = found_ff ? rtk_pkg::ST_DONE : rtk_pkg::ST_MISSING;
               src_in    = rtk_pkg::SRC_ZERO;
               rsel_in   = rtk_pkg::RK_ZERO;
               state_in  = S_FINISH;
            end else begin
               cmd.tbl_op = rtk_pkg::TBL_INC;
               cmd.idx_op = rtk_pkg::IDX_ZERO;
               state_in   = S_SCAN;
            end
         end
         // hand the result to the output register once it is free
         S_FINISH: begin
            if (stat.slot_free) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
      end
      status_ff <= status_in;
      src_ff    <= src_in;
      rsel_ff   <= rsel_in;
   end

endmodule
`default_nettype wire

FILE: rtl/core/rtk_checker.sv
`default_nettype none
`include "assert_macros.svh"
module rtk_checker (
   input wire                  clock,
   input wire                  reset,
   input wire                  req_valid,
   input wire                  req_stall,
   input wire                  rsp_valid,
   input wire                  rsp_stall,
   input rtk_pkg::rtk_rsp_type rsp_word
);
   // a stalled result holds
   `RTK_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word), "result changed while stalled")

   // no unused status code
   `RTK_ASSERT(a_status_code, rsp_valid |-> rsp_word.status != 2'd3, "bad status code")

   // a missing key or rank carries no entry
   `RTK_ASSERT(a_missing_empty, rsp_valid && rsp_word.status == rtk_pkg::ST_MISSING |-> rsp_word.out_key == 32'd0 && rsp_word.out_score == 32'sd0, "entry on missing result")

   // reset drops the result and opens the input
   `RTK_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> !rsp_valid && !req_stall, "not idle after reset")

   // an accepted word blocks the next one
   `RTK_ASSERT(a_one_at_a_time, req_valid && !req_stall |=> req_stall, "second word taken at once")
endmodule

bind top_k_ranking_table rtk_checker u_rtk_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
`default_nettype wire

FILE: dv/tb_top.sv
`default_nettype none
module tb_top;

   localparam int DEPTH      = rtk_pkg::RANK_DEPTH_DEF;
   localparam int TABLES     = rtk_pkg::TABLE_COUNT_DEF;
   localparam int IDLE_LIMIT = 20000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   rtk_pkg::rtk_req_type req_word = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rtk_pkg::rtk_rsp_type rsp_word;
   logic                 csr_wen = 1'b0;
   logic [15:0]          csr_wdata = '0;

   top_k_ranking_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow copy of the tables
   logic                   shadow_used [TABLES][DEPTH];
   rtk_pkg::rtk_entry_type shadow_slot [TABLES][DEPTH];
   logic [15:0]            shadow_min_level;

   rtk_pkg::rtk_rsp_type expected_rsps [$];
   int          error_count = 0;
   int          idle_cycles = 0;
   bit          send_idle_on = 1'b1;
   bit          recv_idle_on = 1'b1;
   bit          hold_off = 1'b0;
   int          hold_cycles = 0;
   int          stall_left = 0;
   logic [31:0] key_pool [16];

   // clear the shadow tables and the minimum level
   task automatic shadow_reset();
      for (int t = 0; t < TABLES; t++)
         for (int r = 0; r < DEPTH; r++) begin
            shadow_used[t][r] = 1'b0;
            shadow_slot[t][r] = '0;
         end
      shadow_min_level = '0;
   endtask

   function automatic int find_rank(int t, logic [31:0] key);
      for (int r = 0; r < DEPTH; r++)
         if (shadow_used[t][r] && shadow_slot[t][r].key == key) return r;
      return DEPTH;
   endfunction

   // drop the entry at rank r and close the gap
   task automatic close_gap(int t, int r);
      for (int i = r; i + 1 < DEPTH; i++) begin
         shadow_used[t][i] = shadow_used[t][i+1];
         shadow_slot[t][i] = shadow_slot[t][i+1];
      end
      shadow_used[t][DEPTH-1] = 1'b0;
      shadow_slot[t][DEPTH-1] = '0;
   endtask

   function automatic rtk_pkg::rtk_rsp_type entry_fields(rtk_pkg::rtk_rsp_type base_rsp,
                                                         rtk_pkg::rtk_entry_type e);
      rtk_pkg::rtk_rsp_type o;
      o = base_rsp;
      o.out_key = e.key; o.out_score = e.score; o.out_group = e.group;
      o.out_title = e.title; o.out_job = e.job; o.out_level = e.level;
      o.out_rebirth = e.rebirth; o.out_sex = e.sex;
      return o;
   endfunction

   // compute the result of one word and advance the shadow tables
   task automatic predict_ranking(input rtk_pkg::rtk_req_type w,
                                  output rtk_pkg::rtk_rsp_type o);
      int t, r, p;
      rtk_pkg::rtk_entry_type e;
      o = '0;
      t = w.table_sel;
      if (w.action == rtk_pkg::ACT_REMOVE_ALL) begin
         o.status = rtk_pkg::ST_MISSING;
         for (int i = 0; i < TABLES; i++) begin
            r = find_rank(i, w.player_key);
            if (r < DEPTH) begin
               close_gap(i, r);
               o.status = rtk_pkg::ST_DONE;
            end
         end
         return;
      end
      if (t >= TABLES) begin
         o.status = rtk_pkg::ST_MISSING;
         return;
      end
      case (w.action)
         rtk_pkg::ACT_UPDATE: begin
            if (w.player_level < shadow_min_level) begin
               o.status = rtk_pkg::ST_IGNORED;
               return;
            end
            r = find_rank(t, w.player_key);
            if (r < DEPTH) begin
               if (shadow_slot[t][r].score == w.score) begin
                  o = entry_fields(o, shadow_slot[t][r]);
                  o.status = rtk_pkg::ST_IGNORED;
                  o.out_rank = r[5:0];
                  return;
               end
               close_gap(t, r);
            end
            for (p = 0; p < DEPTH; p++)
               if (!shadow_used[t][p] || shadow_slot[t][p].score < w.score) break;
            if (p >= DEPTH) begin
               o.status = rtk_pkg::ST_IGNORED;
               return;
            end
            for (int i = DEPTH - 1; i > p; i--) begin
               shadow_used[t][i] = shadow_used[t][i-1];
               shadow_slot[t][i] = shadow_slot[t][i-1];
            end
            e.key = w.player_key; e.score = w.score; e.group = w.group_id;
            e.title = w.title_id; e.job = w.job_class; e.level = w.player_level;
            e.rebirth = w.rebirth_level; e.sex = w.sex_flag;
            shadow_used[t][p] = 1'b1;
            shadow_slot[t][p] = e;
            o = entry_fields(o, e);
            o.out_rank = p[5:0];
         end
         rtk_pkg::ACT_LOOKUP, rtk_pkg::ACT_SET_GROUP, rtk_pkg::ACT_REMOVE: begin
            r = find_rank(t, w.player_key);
            if (r >= DEPTH) begin
               o.status = rtk_pkg::ST_MISSING;
               return;
            end
            o.out_rank = r[5:0];
            if (w.action == rtk_pkg::ACT_REMOVE) close_gap(t, r);
            else begin
               if (w.action == rtk_pkg::ACT_SET_GROUP) shadow_slot[t][r].group = w.group_id;
               o = entry_fields(o, shadow_slot[t][r]);
            end
         end
         rtk_pkg::ACT_READ_RANK, rtk_pkg::ACT_CLEAR_RANK: begin
            o.out_rank = w.rank_index;
            if (w.rank_index >= DEPTH || !shadow_used[t][w.rank_index]) begin
               o.status = rtk_pkg::ST_MISSING;
               return;
            end
            if (w.action == rtk_pkg::ACT_READ_RANK)
               o = entry_fields(o, shadow_slot[t][w.rank_index]);
            else close_gap(t, w.rank_index);
         end
         default: begin
            for (int i = 0; i < DEPTH; i++) begin
               shadow_used[t][i] = 1'b0;
               shadow_slot[t][i] = '0;
            end
         end
      endcase
   endtask

   // offer one word, possibly after a random gap, hold it until accepted, then drop valid
   task automatic send_word(rtk_pkg::rtk_req_type w);
      rtk_pkg::rtk_rsp_type o;
      int gap;
      if (send_idle_on && $urandom_range(3) == 0) begin
         gap = $urandom_range(9, 1);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_ranking(w, o);
      expected_rsps.push_back(o);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait until every result is back, then let the block settle
   task automatic drain();
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (8 * DEPTH) @(posedge clock);
   endtask

   task automatic write_min_level(logic [15:0] v);
      drain();
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 1'b0;
      shadow_min_level = v;
   endtask

   function automatic rtk_pkg::rtk_req_type random_word(bit well_formed);
      rtk_pkg::rtk_req_type w;
      logic [191:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      w = raw[$bits(rtk_pkg::rtk_req_type)-1:0];
      if (well_formed) begin
         w.table_sel = 3'($urandom_range(3));
         w.player_key = key_pool[$urandom_range(15)];
         w.score = $signed(32'($urandom_range(20))) - 32'sd10;
         if ($urandom_range(3) == 0) w.score = $urandom;
         w.rank_index = 6'($urandom_range(15));
         if ($urandom_range(5) != 0) w.action = rtk_pkg::ACT_UPDATE;
         if (w.action == rtk_pkg::ACT_CLEAR_TBL && $urandom_range(3) != 0)
            w.action = rtk_pkg::ACT_LOOKUP;
      end
      return w;
   endfunction

   // directed: field extremes and every action
   task automatic test_directed();
      rtk_pkg::rtk_req_type w;
      w = '0;
      w.player_key = 32'hFFFF_FFFF; w.score = 32'sh7FFF_FFFF; w.group_id = '1;
      w.title_id = '1; w.job_class = '1; w.player_level = '1; w.rebirth_level = '1;
      w.sex_flag = 1'b1;
      send_word(w);
      send_word(w);                    // same score
      w.score = 32'sh8000_0000; send_word(w);
      w.player_key = '0; w.score = '0; w.group_id = '0; w.title_id = '0; w.job_class = '0;
      w.player_level = '0; w.rebirth_level = '0; w.sex_flag = 1'b0;
      send_word(w);
      w.action = rtk_pkg::ACT_LOOKUP; send_word(w);
      w.action = rtk_pkg::ACT_SET_GROUP; w.group_id = 16'h1234; send_word(w);
      w.action = rtk_pkg::ACT_READ_RANK; w.rank_index = '0; send_word(w);
      w.rank_index = 6'd63; send_word(w);
      w.action = rtk_pkg::ACT_CLEAR_RANK; w.rank_index = 6'd1; send_word(w);
      w.rank_index = 6'd63; send_word(w);
      w.action = rtk_pkg::ACT_REMOVE; send_word(w);
      w.player_key = 32'h5; send_word(w);
      w.action = rtk_pkg::ACT_UPDATE; w.table_sel = 3'd7; send_word(w);
      w.action = rtk_pkg::ACT_REMOVE_ALL; send_word(w);
      w.player_key = 32'hFFFF_FFFF; send_word(w);
      w.action = rtk_pkg::ACT_CLEAR_TBL; send_word(w);
      w.action = rtk_pkg::ACT_READ_RANK; w.rank_index = '0; send_word(w);
      write_min_level(16'hFFFF);
      w.action = rtk_pkg::ACT_UPDATE; w.player_level = 16'hFFFE; send_word(w);
      w.player_level = 16'hFFFF; send_word(w);
      write_min_level(16'h0000);
   endtask

   // fill one table past capacity so further entries get refused
   task automatic test_full_table();
      rtk_pkg::rtk_req_type w;
      for (int i = 0; i < DEPTH + 8; i++) begin
         w = random_word(1'b0);
         w.action = rtk_pkg::ACT_UPDATE; w.table_sel = 3'd5; w.player_key = i;
         w.score = (i < DEPTH) ? 100 : 50;
         send_word(w);
      end
      w.action = rtk_pkg::ACT_READ_RANK; w.rank_index = 6'd63; send_word(w);
      w.action = rtk_pkg::ACT_UPDATE; w.player_key = 3; w.score = 100; send_word(w);
      w.player_key = 3; w.score = 20; send_word(w);
   endtask

   // receiver holds off long so the block backs up
   task automatic test_backpressure();
      hold_off = 1'b1;
      for (int i = 0; i < 6; i++) send_word(random_word(1'b1));
      while (hold_off) @(posedge clock);
   endtask

   task automatic test_random(int count, bit with_idle);
      send_idle_on = with_idle;
      recv_idle_on = with_idle;
      for (int i = 0; i < count; i++) begin
         send_word(random_word($urandom_range(9) != 0));
         if (i % 300 == 299) write_min_level(16'($urandom_range(3)));
      end
   endtask

   // receiver stall pattern: a long hold, or random stall bursts
   always @(posedge clock) begin
      if (hold_off) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles + 1;
         if (hold_cycles >= 400) begin
            hold_off <= 1'b0;
            hold_cycles <= 0;
         end
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (recv_idle_on && $urandom_range(7) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(8);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result word %h", rsp_word);
            error_count++;
         end else begin
            rtk_pkg::rtk_rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_word.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_word.status);
               error_count++;
            end
            if (rsp_word.out_key !== e.out_key) begin
               $error("out_key exp %h got %h", e.out_key, rsp_word.out_key);
               error_count++;
            end
            if (rsp_word.out_score !== e.out_score) begin
               $error("out_score exp %0d got %0d", e.out_score, rsp_word.out_score);
               error_count++;
            end
            if (rsp_word.out_group !== e.out_group) begin
               $error("out_group exp %h got %h", e.out_group, rsp_word.out_group);
               error_count++;
            end
            if (rsp_word.out_title !== e.out_title) begin
               $error("out_title exp %h got %h", e.out_title, rsp_word.out_title);
               error_count++;
            end
            if (rsp_word.out_job !== e.out_job) begin
               $error("out_job exp %h got %h", e.out_job, rsp_word.out_job);
               error_count++;
            end
            if (rsp_word.out_level !== e.out_level) begin
               $error("out_level exp %h got %h", e.out_level, rsp_word.out_level);
               error_count++;
            end
            if (rsp_word.out_rebirth !== e.out_rebirth) begin
               $error("out_rebirth exp %h got %h", e.out_rebirth, rsp_word.out_rebirth);
               error_count++;
            end
            if (rsp_word.out_sex !== e.out_sex) begin
               $error("out_sex exp %b got %b", e.out_sex, rsp_word.out_sex);
               error_count++;
            end
            if (rsp_word.out_rank !== e.out_rank) begin
               $error("out_rank exp %0d got %0d", e.out_rank, rsp_word.out_rank);
               error_count++;
            end
         end
      end
   end

   // watchdog: count cycles with no accepted word on either side and no long hold; end the run with errors at the limit
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || hold_off)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      shadow_reset();
      for (int i = 0; i < 16; i++)
         key_pool[i] = (i < 2) ? (i == 0 ? 32'h0 : 32'hFFFF_FFFF) : $urandom;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_table();
      test_backpressure();
      test_random(1100, 1'b1);
      test_random(250, 1'b0);
      drain();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+rtl/core
rtl/core/rtk_pkg.sv
rtl/core/rtk_dpath.sv
rtl/core/rtk_ctrl.sv
rtl/core/top_k_ranking_table.sv
rtl/core/rtk_checker.sv
dv/tb_top.sv
